// ===== design/pulse_width_nibble_deframer_unit_macros.svh =====
// assertion macros for the pulse width nibble deframer checker
`ifndef PULSE_WIDTH_NIBBLE_DEFRAMER_UNIT_MACROS_SVH
`define PULSE_WIDTH_NIBBLE_DEFRAMER_UNIT_MACROS_SVH

// checked only out of reset
`define PWND_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define PWND_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/pwnd_pkg.sv =====
// shared types and constants for the pulse width nibble deframer
package pwnd_pkg;

  localparam int unsigned WIDTH_W   = 16;
  localparam int unsigned CODE_W    = 5;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned NIBBLE_W  = 4;
  localparam int unsigned WIN_SHIFT = 6;

  localparam logic [WIDTH_W-1:0] WIDTH_LO = 16'd992;
  localparam logic [WIDTH_W-1:0] WIDTH_HI = 16'd2080;

  localparam logic [CODE_W-1:0] IDLE_CODE    = 5'd16;
  localparam logic [CODE_W-1:0] UNKNOWN_CODE = 5'd17;

  localparam logic [CHAR_W-1:0] MAX_LEN_RESET = 8'd32;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_IDLE = 2'd1,
    EV_CHAR = 2'd2
  } event_t;

  typedef struct packed {
    event_t              kind;
    logic [CODE_W-1:0]   code;
    logic [CHAR_W-1:0]   char_value;
    logic [CHAR_W-1:0]   char_position;
    logic                char_stored;
    logic [CHAR_W-1:0]   report;
  } result_t;

endpackage

// ===== design/pwnd_classify.sv =====
// sorts one pulse width into its window code
module pwnd_classify (
  input  logic [pwnd_pkg::WIDTH_W-1:0] width_us,
  output logic [pwnd_pkg::CODE_W-1:0]  code
);

  logic [pwnd_pkg::WIDTH_W-1:0] offset;

  assign offset = width_us - pwnd_pkg::WIDTH_LO - 16'd1;

  always_comb begin
    if (width_us < pwnd_pkg::WIDTH_LO || width_us > pwnd_pkg::WIDTH_HI) begin
      code = pwnd_pkg::UNKNOWN_CODE;
    end else if (width_us == pwnd_pkg::WIDTH_LO) begin
      code = '0;
    end else begin
      code = offset[pwnd_pkg::WIN_SHIFT +: pwnd_pkg::CODE_W];
    end
  end

endmodule

// ===== design/pwnd_msg_ctrl.sv =====
// nibble phase, character assembly and message count
module pwnd_msg_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [pwnd_pkg::CODE_W-1:0]  code,
  input  logic [pwnd_pkg::CHAR_W-1:0]  max_len,
  output pwnd_pkg::result_t            res
);

  logic                        low_exp_r, low_exp_nxt;
  logic [pwnd_pkg::CHAR_W-1:0] pending_r, pending_nxt;
  logic [pwnd_pkg::CHAR_W-1:0] count_r, count_nxt;

  always_comb begin
    low_exp_nxt       = low_exp_r;
    pending_nxt       = pending_r;
    count_nxt         = count_r;
    res.kind          = pwnd_pkg::EV_NONE;
    res.code          = code;
    res.char_value    = '0;
    res.char_position = '0;
    res.char_stored   = 1'b0;
    res.report        = '0;
    if (code == pwnd_pkg::UNKNOWN_CODE) begin
      low_exp_nxt = 1'b0;
    end else if (code == pwnd_pkg::IDLE_CODE) begin
      low_exp_nxt = 1'b0;
      res.kind    = pwnd_pkg::EV_IDLE;
      res.report  = count_r;
      count_nxt   = '0;
    end else if (!low_exp_r) begin
      pending_nxt = {code[pwnd_pkg::NIBBLE_W-1:0], {pwnd_pkg::NIBBLE_W{1'b0}}};
      low_exp_nxt = 1'b1;
    end else begin
      pending_nxt    = pending_r | {{pwnd_pkg::NIBBLE_W{1'b0}}, code[pwnd_pkg::NIBBLE_W-1:0]};
      low_exp_nxt    = 1'b0;
      res.kind       = pwnd_pkg::EV_CHAR;
      res.char_value = pending_nxt;
      if (count_r < max_len) begin
        res.char_position = count_r;
        res.char_stored   = 1'b1;
        count_nxt         = count_r + 8'd1;
      end else begin
        res.report = 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_exp_r <= 1'b0;
      pending_r <= '0;
      count_r   <= '0;
    end else if (advance) begin
      low_exp_r <= low_exp_nxt;
      pending_r <= pending_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

// ===== design/pulse_width_nibble_deframer_unit.sv =====
// top level of the pulse width nibble deframer
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | in_pulse_width_us
//  out_    | output    | out_valid/out_stall | event, code, char, position, stored, report
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_max_message_length
//
// one pulse per cycle sustained while the output is not stalled; the path from input to result:
// input register, one pass of classify and message logic, result register
// reset clears the phase, the count, both valid flags and sets the limit to 32
// a stalled result holds and one more pulse waits in the input register
module pulse_width_nibble_deframer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pwnd_pkg::WIDTH_W-1:0]  in_pulse_width_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_event_kind,
  output logic [pwnd_pkg::CODE_W-1:0]   out_nibble_code,
  output logic [pwnd_pkg::CHAR_W-1:0]   out_char_value,
  output logic [pwnd_pkg::CHAR_W-1:0]   out_char_position,
  output logic                          out_char_stored,
  output logic [pwnd_pkg::CHAR_W-1:0]   out_message_report,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pwnd_pkg::CHAR_W-1:0]   cfg_max_message_length
);

  logic                         in_valid_r;
  logic [pwnd_pkg::WIDTH_W-1:0] width_r;
  logic                         out_valid_r;
  pwnd_pkg::result_t            res_r;
  pwnd_pkg::result_t            res;
  logic [pwnd_pkg::CHAR_W-1:0]  max_len_r;
  logic [pwnd_pkg::CODE_W-1:0]  code;
  logic                         advance;
  logic                         in_xfer;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  pwnd_classify u_classify (
    .width_us (width_r),
    .code     (code)
  );

  pwnd_msg_ctrl u_msg_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .code    (code),
    .max_len (max_len_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_len_r   <= pwnd_pkg::MAX_LEN_RESET;
    end else begin
      if (in_xfer) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        max_len_r <= cfg_max_message_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      width_r <= in_pulse_width_us;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_kind     = res_r.kind;
  assign out_nibble_code    = res_r.code;
  assign out_char_value     = res_r.char_value;
  assign out_char_position  = res_r.char_position;
  assign out_char_stored    = res_r.char_stored;
  assign out_message_report = res_r.report;

endmodule

// ===== design/pwnd_checker.sv =====
// port level checks for the pulse width nibble deframer
`include "pulse_width_nibble_deframer_unit_macros.svh"

module pwnd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_event_kind,
  input logic [pwnd_pkg::CODE_W-1:0]   out_nibble_code,
  input logic [pwnd_pkg::CHAR_W-1:0]   out_char_value,
  input logic                          out_char_stored,
  input logic [pwnd_pkg::CHAR_W-1:0]   out_message_report
);

  `PWND_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid, "result valid right after reset")

  `PWND_ASSERT(a_stall_holds, out_valid && out_stall |=> out_valid && $stable(out_char_value), "stalled result changed")

  `PWND_ASSERT(a_stored_is_char, out_valid && out_char_stored |-> out_event_kind == pwnd_pkg::EV_CHAR, "character stored without completion")

  `PWND_ASSERT(a_unknown_quiet, out_valid && out_nibble_code == pwnd_pkg::UNKNOWN_CODE |-> out_event_kind == pwnd_pkg::EV_NONE && out_message_report == 8'd0, "unknown width produced an event")

  `PWND_ASSERT(a_overflow_report, out_valid && out_event_kind == pwnd_pkg::EV_CHAR && !out_char_stored |-> out_message_report == 8'd1, "overflow character without report")

endmodule

bind pulse_width_nibble_deframer_unit pwnd_checker u_pwnd_checker (.*);
